[rtl/core/ssof_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssof_pkg
// Shared types and constants of the sensor spike and outlier filter.
// ----------------------------------------------------------------------------
package ssof_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int JUMP_WIDTH       = 8;
  localparam int ALARM_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH  = 8;
  localparam int CFG_DATA_WIDTH   = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_JUMP_LIMIT  = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALARM_LIMIT = 8'd1;

  localparam logic [JUMP_WIDTH-1:0]         JUMP_LIMIT_RESET  = 8'd10;
  localparam logic signed [ALARM_WIDTH-1:0] ALARM_LIMIT_RESET = 16'sd500;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_RISE  = 2'd1;
  localparam logic [1:0] DIR_FALL  = 2'd2;
  localparam logic [1:0] ALARM_SAT = 2'd3;

  typedef struct packed {
    logic [JUMP_WIDTH-1:0]         jump_limit;
    logic signed [ALARM_WIDTH-1:0] alarm_limit;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/core/ssof_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssof_cfg
// Configuration register file: jump limit and alarm limit.
// ----------------------------------------------------------------------------
module ssof_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ssof_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [ssof_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output ssof_pkg::cfg_t                            cfg
);

  ssof_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.jump_limit  <= ssof_pkg::JUMP_LIMIT_RESET;
      regs.alarm_limit <= ssof_pkg::ALARM_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssof_pkg::REG_JUMP_LIMIT: begin
          regs.jump_limit <= cfg_data[ssof_pkg::JUMP_WIDTH-1:0];
        end
        ssof_pkg::REG_ALARM_LIMIT: begin
          regs.alarm_limit <= $signed(cfg_data[ssof_pkg::ALARM_WIDTH-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/ssof_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssof_step
// Filter state and the per-sample spike, alarm and zero-hold decision.
// ----------------------------------------------------------------------------
module ssof_step #(
  parameter int SAMPLE_WIDTH = ssof_pkg::SAMPLE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic signed [SAMPLE_WIDTH-1:0] raw,
  input  wire ssof_pkg::cfg_t                 cfg,
  output logic signed [SAMPLE_WIDTH-1:0]      result
);

  localparam int DW = SAMPLE_WIDTH + 2;
  localparam int AW = ((SAMPLE_WIDTH > ssof_pkg::ALARM_WIDTH) ?
                       SAMPLE_WIDTH : ssof_pkg::ALARM_WIDTH) + 2;

  logic                           primed;
  logic signed [SAMPLE_WIDTH-1:0] previous_raw;
  logic [1:0]                     jump_direction;
  logic [1:0]                     alarm_count;
  logic signed [SAMPLE_WIDTH-1:0] normal_value;
  logic signed [SAMPLE_WIDTH-1:0] last_output;

  logic [1:0]                     jump_direction_next;
  logic [1:0]                     alarm_count_next;
  logic signed [SAMPLE_WIDTH-1:0] normal_value_next;

  logic signed [DW-1:0]           diff;
  logic signed [DW-1:0]           neg_diff;
  logic signed [DW-1:0]           lim;
  logic signed [SAMPLE_WIDTH-1:0] jump_val;
  logic signed [AW-1:0]           val_x;
  logic signed [AW-1:0]           alim;
  logic signed [AW-1:0]           neg_alim;
  logic                           alarm;
  logic [1:0]                     count_inc;
  logic signed [SAMPLE_WIDTH-1:0] val;

  always_comb begin
    diff     = DW'(raw) - DW'(previous_raw);
    neg_diff = -diff;
    lim      = DW'($signed({1'b0, cfg.jump_limit}));

    jump_val            = raw;
    jump_direction_next = ssof_pkg::DIR_NONE;
    if (diff >= lim) begin
      if (jump_direction != ssof_pkg::DIR_FALL) begin
        jump_val = previous_raw;
      end
      jump_direction_next = ssof_pkg::DIR_RISE;
    end else if (neg_diff >= lim) begin
      if (jump_direction != ssof_pkg::DIR_RISE) begin
        jump_val = previous_raw;
      end
      jump_direction_next = ssof_pkg::DIR_FALL;
    end

    val_x    = AW'(jump_val);
    alim     = AW'(cfg.alarm_limit);
    neg_alim = -alim;
    alarm    = (!alim[AW-1] && (alim != '0) && (val_x > alim)) ||
               (alim[AW-1] && (val_x < neg_alim));

    count_inc = (alarm_count == ssof_pkg::ALARM_SAT) ? ssof_pkg::ALARM_SAT :
                alarm_count + 2'd1;

    if (!primed) begin
      val                 = raw;
      jump_direction_next = jump_direction;
      alarm_count_next    = alarm_count;
      normal_value_next   = normal_value;
    end else if (alarm) begin
      alarm_count_next  = count_inc;
      normal_value_next = normal_value;
      val = (count_inc != ssof_pkg::ALARM_SAT) ? normal_value : jump_val;
    end else begin
      alarm_count_next  = 2'd0;
      normal_value_next = jump_val;
      val               = jump_val;
    end

    result = (val == '0) ? last_output : val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed         <= 1'b0;
      previous_raw   <= '0;
      jump_direction <= ssof_pkg::DIR_NONE;
      alarm_count    <= 2'd0;
      normal_value   <= '0;
      last_output    <= '0;
    end else if (advance) begin
      primed         <= 1'b1;
      previous_raw   <= raw;
      jump_direction <= jump_direction_next;
      alarm_count    <= alarm_count_next;
      normal_value   <= normal_value_next;
      last_output    <= result;
    end
  end

`ifndef SYNTHESIS
  a_primed_after_request: assert property (@(posedge clk) disable iff (rst)
    advance |=> primed)
    else $error("filter not primed after a request");

  a_zero_only_from_zero_hold: assert property (@(posedge clk) disable iff (rst)
    advance && (result == '0) |-> (last_output == '0))
    else $error("zero result while last output is nonzero");
`endif

endmodule
`default_nettype wire

[rtl/core/sensor_spike_outlier_filter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_spike_outlier_filter_unit
// Spike rejection, alarm hold and zero hold on a signed sensor sample stream.
//
//   channel    signals                                   direction
//   sample     sample_valid, sample_ready, sample        in
//   filtered   filtered_valid, filtered_ready, filtered  out
//   cfg        cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// One request per cycle sustained while the output is not stalled. A request
// is held in the input register, and the filter state loop updates as it
// leaves the input register for the output register.
// Synchronous reset clears the filter state and loads the default limits.
// A stalled output holds the input register; a new request is still taken in
// the same cycle the output is taken.
// ----------------------------------------------------------------------------
module sensor_spike_outlier_filter_unit #(
  parameter int SAMPLE_WIDTH = ssof_pkg::SAMPLE_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 sample_valid,
  output logic                                      sample_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sample,
  output logic                                      filtered_valid,
  input  wire logic                                 filtered_ready,
  output logic signed [SAMPLE_WIDTH-1:0]            filtered,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ssof_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [ssof_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  ssof_pkg::cfg_t                 cfg;
  logic                           stage_valid;
  logic signed [SAMPLE_WIDTH-1:0] stage_sample;
  logic                           advance;
  logic signed [SAMPLE_WIDTH-1:0] result;

  ssof_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssof_step #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .raw     (stage_sample),
    .cfg     (cfg),
    .result  (result)
  );

  assign advance      = stage_valid && (!filtered_valid || filtered_ready);
  assign sample_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      stage_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_valid <= 1'b0;
    end else if (advance) begin
      filtered_valid <= 1'b1;
    end else if (filtered_ready) begin
      filtered_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered <= result;
    end
  end

`ifndef SYNTHESIS
  a_no_advance_on_stall: assert property (@(posedge clk) disable iff (rst)
    filtered_valid && !filtered_ready |-> !advance)
    else $error("request advanced into a stalled output");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |-> !stage_valid || advance)
    else $error("input register overwritten");

  a_advance_shows_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> filtered_valid)
    else $error("advanced request not shown on output");
`endif

endmodule
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor spike and outlier filter. A behavioral
// copy of the filter predicts each filtered sample from the accepted raw
// samples and the current limits. A receiver process compares every output
// request in order. Directed corners come first: priming, rise and fall
// spikes, direction reversal, alarm hold and saturation, zero hold, limit
// extremes and ignored register writes. Randomized phases under several limit
// settings follow, with random idling on both channels, a long output stall
// and a paused sender.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW          = ssof_pkg::SAMPLE_WIDTH;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [ssof_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE  = 8'd2;
  localparam logic [ssof_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 8'hff;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 sample_valid = 1'b0;
  logic                                 sample_ready;
  logic signed [SW-1:0]                 sample = '0;
  logic                                 filtered_valid;
  logic                                 filtered_ready = 1'b0;
  logic signed [SW-1:0]                 filtered;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [ssof_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [ssof_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  logic signed [SW-1:0] expected_filtered[$];
  int unsigned          mismatches = 0;
  int unsigned          cycle_count = 0;
  bit                   send_idle = 1'b0;
  bit                   recv_idle = 1'b0;
  int unsigned          hold_cycles = 0;
  int                   walk = 0;

  // shadow limits and filter state
  logic [ssof_pkg::JUMP_WIDTH-1:0]         cfg_jump = ssof_pkg::JUMP_LIMIT_RESET;
  logic signed [ssof_pkg::ALARM_WIDTH-1:0] cfg_alarm = ssof_pkg::ALARM_LIMIT_RESET;
  bit                                      primed = 1'b0;
  logic signed [SW-1:0]                    prev_raw = '0;
  logic [1:0]                              jump_dir = ssof_pkg::DIR_NONE;
  logic [1:0]                              alarm_cnt = '0;
  logic signed [SW-1:0]                    normal_val = '0;
  logic signed [SW-1:0]                    last_out = '0;

  sensor_spike_outlier_filter_unit dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .filtered_valid (filtered_valid),
    .filtered_ready (filtered_ready),
    .filtered       (filtered),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout, %0d filtered samples pending", $time, expected_filtered.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [SW-1:0] filtered_for(input logic signed [SW-1:0] raw);
    int  d;
    int  v;
    int  lim;
    int  alim;
    bit  alarm;
    v = int'(raw);
    if (primed) begin
      lim  = int'(cfg_jump);
      alim = int'(cfg_alarm);
      d    = int'(raw) - int'(prev_raw);
      if (d >= lim) begin
        if (jump_dir != ssof_pkg::DIR_FALL) v = int'(prev_raw);
        jump_dir = ssof_pkg::DIR_RISE;
      end else if (-d >= lim) begin
        if (jump_dir != ssof_pkg::DIR_RISE) v = int'(prev_raw);
        jump_dir = ssof_pkg::DIR_FALL;
      end else begin
        jump_dir = ssof_pkg::DIR_NONE;
      end
      alarm = (alim > 0 && v > alim) || (alim < 0 && v < -alim);
      if (alarm) begin
        if (alarm_cnt < ssof_pkg::ALARM_SAT) alarm_cnt = alarm_cnt + 2'd1;
        if (alarm_cnt < ssof_pkg::ALARM_SAT) v = int'(normal_val);
      end else begin
        normal_val = v[SW-1:0];
        alarm_cnt  = '0;
      end
    end else begin
      primed = 1'b1;
    end
    prev_raw = raw;
    if (v == 0) v = int'(last_out);
    else last_out = v[SW-1:0];
    return v[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] next_reading();
    int step;
    int mag;
    int v;
    step = (cfg_jump == 0) ? 4 : int'(cfg_jump);
    mag  = (cfg_alarm < 0) ? -int'(cfg_alarm) : int'(cfg_alarm);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = walk + int'($urandom_range(0, 2 * step)) - step;
      4, 5: v = walk + ($urandom_range(0, 1) ? 1 : -1) *
                (step + int'($urandom_range(0, 3 * step)));
      6: v = mag + int'($urandom_range(0, 20)) - 10;
      7: v = 0;
      8: v = int'($urandom_range(0, 16'hffff)) - 32768;
      default: v = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    walk = v;
    return v[SW-1:0];
  endfunction

  task automatic send_sample(input logic signed [SW-1:0] s);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    expected_filtered.push_back(filtered_for(s));
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(posedge clk); while (expected_filtered.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ssof_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [ssof_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ssof_pkg::REG_JUMP_LIMIT) cfg_jump = data[ssof_pkg::JUMP_WIDTH-1:0];
    else if (idx == ssof_pkg::REG_ALARM_LIMIT) cfg_alarm = data[ssof_pkg::ALARM_WIDTH-1:0];
    @(posedge clk);
  endtask

  initial begin : receiver
    int unsigned          stall;
    logic signed [SW-1:0] want;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = recv_idle ? $urandom_range(0, 7) : 0;
      end
      if (stall != 0) begin
        filtered_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      filtered_ready <= 1'b1;
      do @(posedge clk); while (!(filtered_valid && filtered_ready));
      if (expected_filtered.size() == 0) begin
        $display("%0t unexpected filtered request: expected none, actual %0d", $time, filtered);
        mismatches++;
      end else begin
        want = expected_filtered.pop_front();
        if (filtered !== want) begin
          $display("%0t filtered mismatch: expected %0d, actual %0d", $time, want, filtered);
          mismatches++;
        end
      end
    end
  end

  task automatic test_default_limits();
    logic signed [SW-1:0] seq[$];
    seq = '{16'sd0, 16'sd5, 16'sd100, 16'sd30, 16'sd200, 16'sd205, 16'sd600, 16'sd700,
            16'sd705, 16'sd708, 16'sd710, 16'sd3, 16'sd32767, -16'sd32768};
    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (seq[i]) send_sample(seq[i]);
    wait_drained();
  endtask

  task automatic test_limit_corners();
    write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'h0000);
    write_limit(ssof_pkg::REG_ALARM_LIMIT, 16'h8000);
    send_sample(16'sd100);
    send_sample(16'sd100);
    send_sample(16'sd50);
    wait_drained();
    // drop the high byte of the jump limit
    write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'hab05);
    write_limit(ssof_pkg::REG_ALARM_LIMIT, 16'hffff);
    send_sample(16'sd0);
    send_sample(16'sd7);
    send_sample(16'sd20);
    wait_drained();
    write_limit(REG_SPARE, 16'h1234);
    write_limit(REG_UNUSED, 16'hffff);
    send_sample(16'sd25);
    send_sample(16'sd40);
    wait_drained();
    write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'h00ff);
    write_limit(ssof_pkg::REG_ALARM_LIMIT, 16'h7fff);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd100);
    wait_drained();
  endtask

  task automatic test_random_limits();
    int                                      phase;
    logic signed [ssof_pkg::ALARM_WIDTH-1:0] lim16;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'd0);
          write_limit(ssof_pkg::REG_ALARM_LIMIT, 16'd0);
        end
        1: begin
          write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'd255);
          write_limit(ssof_pkg::REG_ALARM_LIMIT, 16'h7fff);
        end
        2: begin
          write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'($urandom_range(1, 40)));
          write_limit(ssof_pkg::REG_ALARM_LIMIT, 16'($urandom_range(1, 2000)));
        end
        3: begin
          lim16 = 16'($urandom_range(1, 2000));
          lim16 = -lim16;
          write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'($urandom_range(1, 40)));
          write_limit(ssof_pkg::REG_ALARM_LIMIT, lim16);
        end
        4: begin
          write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'd10);
          write_limit(ssof_pkg::REG_ALARM_LIMIT, 16'h8000);
        end
        default: begin
          write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'($urandom_range(0, 16'hffff)));
          write_limit(ssof_pkg::REG_ALARM_LIMIT, 16'($urandom_range(0, 16'hffff)));
        end
      endcase
      send_idle = (phase % 3) != 2;
      recv_idle = (phase % 3) != 1;
      repeat (100) send_sample(next_reading());
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    write_limit(ssof_pkg::REG_JUMP_LIMIT, 16'd20);
    write_limit(ssof_pkg::REG_ALARM_LIMIT, 16'd300);
    send_idle   = 1'b0;
    recv_idle   = 1'b0;
    hold_cycles = 48;
    repeat (16) send_sample(next_reading());
    wait_drained();
  endtask

  task automatic test_paused_sender();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (10) send_sample(next_reading());
    // hold until every filtered sample is back
    wait_drained();
    repeat (10) send_sample(next_reading());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_default_limits();
    test_limit_corners();
    test_random_limits();
    test_backpressure();
    test_paused_sender();
    repeat (8) @(posedge clk);
    if (expected_filtered.size() != 0)
      $display("%0t %0d filtered samples never arrived", $time, expected_filtered.size());
    if (mismatches == 0 && expected_filtered.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ssof_pkg.sv
rtl/core/ssof_cfg.sv
rtl/core/ssof_step.sv
rtl/core/sensor_spike_outlier_filter_unit.sv
verif/tb_top.sv
